[hw/rtl/tlnf_pkg.sv]
// shared types and character constants for the line number filter
`default_nettype none

package tlnf_pkg;

    // characters
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CTRL_OFS = 8'd64;

    // blank run code while inside a line
    localparam logic [2:0] MID_LINE = 3'd7;

    // configuration register indexes
    localparam logic [1:0] REG_NUMBER_MODE   = 2'd0;
    localparam logic [1:0] REG_SHOW_ENDS     = 2'd1;
    localparam logic [1:0] REG_SHOW_TABS     = 2'd2;
    localparam logic [1:0] REG_SQUEEZE_BLANK = 2'd3;

    // numbering modes
    localparam logic [1:0] NUM_OFF = 2'd0;
    localparam logic [1:0] NUM_ALL = 2'd1;

    // sequencer to digit unit
    typedef struct packed {
        logic bump_start;
        logic bump_step;
        logic emit_start;
        logic emit_step;
    } dig_ctrl_t;

    // digit unit to sequencer
    typedef struct packed {
        logic       bump_done;
        logic       emit_last;
        logic [7:0] digit_char;
    } dig_stat_t;

endpackage

`default_nettype wire

[hw/rtl/text_line_number_filter_top.sv]
// top level of the cat-style line numbering byte filter
`default_nettype none

// Byte filter in the manner of cat: each input transaction carries one text byte and
// produces the output bytes written for it, the final one flagged with last_of_run.
// Plain bytes go straight into the output register, one per cycle unless the output
// stalls. A tab shown as "^I" or a newline preceded by '$' gives two bytes, the second
// from a held state. A squeezed blank line gives no output at all. At a numbered line
// start the block stalls its input while a small sequencer drives the prefix through
// the shared digit unit: it accepts the byte, increments the counter with the carry
// rippled one digit at a time (1 to DIGITS digits), sends the leading spaces (MIN_WIDTH
// minus digits in use, when positive), the digits shown and the tab, then the line's
// own bytes. Line state carries over between files. The user must write configuration
// through a plain write port while the block is idle; the block does not enforce it.
module text_line_number_filter_top
    import tlnf_pkg::*;
#(
    parameter int DIGITS    = 18,
    parameter int MIN_WIDTH = 6
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration write port
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [1:0] cfg_data,
    // input channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    // output channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_of_run
);

    localparam int UW = $clog2(DIGITS + 1);
    localparam int CW = $clog2(((DIGITS > MIN_WIDTH) ? DIGITS : MIN_WIDTH) + 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_BUMP   = 4'd1;
    localparam logic [3:0] ST_PAD    = 4'd2;
    localparam logic [3:0] ST_DIG    = 4'd3;
    localparam logic [3:0] ST_TAB    = 4'd4;
    localparam logic [3:0] ST_DOLLAR = 4'd5;
    localparam logic [3:0] ST_NL     = 4'd6;
    localparam logic [3:0] ST_CARET  = 4'd7;
    localparam logic [3:0] ST_CHAR   = 4'd8;

    // configuration registers
    logic [1:0] number_mode_reg;
    logic       show_ends_reg;
    logic       show_tabs_reg;
    logic       squeeze_reg;

    // sequencer state
    logic [3:0]    state_reg, state_next;
    logic [7:0]    byte_reg, byte_next;
    logic          esc_reg, esc_next;
    logic [CW-1:0] pad_reg, pad_next;
    logic [2:0]    blank_reg, blank_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    // emission and handshake
    logic          out_free;
    logic          accept;
    logic          emit_en;
    logic [7:0]    emit_byte;
    logic          emit_last;
    logic          out_load;

    // line start decisions for the incoming byte
    logic          in_is_nl;
    logic          in_esc;
    logic          mid_line;
    logic          squeezed;
    logic          do_number;
    logic [3:0]    tail_state;

    dig_ctrl_t     dig_ctrl;
    dig_stat_t     dig_stat;
    logic [UW-1:0] digits_used;

    tlnf_digits #(
        .DIGITS (DIGITS)
    ) u_digits (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (dig_ctrl),
        .stat        (dig_stat),
        .digits_used (digits_used)
    );

    // output slot can take a byte this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign out_load = emit_en && out_free;

    assign in_is_nl = (in_byte == CH_NL);
    assign in_esc   = (in_byte == CH_TAB) && show_tabs_reg;
    assign mid_line = (blank_reg == MID_LINE);
    // second or later blank line of a run
    assign squeezed = in_is_nl && !mid_line && (blank_reg != 3'd0) && squeeze_reg;

    always_comb
    begin
        if (in_is_nl)
        begin
            do_number = !mid_line && !squeezed && (number_mode_reg == NUM_ALL);
        end
        else
        begin
            do_number = !mid_line && (number_mode_reg != NUM_OFF);
        end
    end

    // what follows the number prefix
    always_comb
    begin
        if (byte_reg == CH_NL)
        begin
            tail_state = show_ends_reg ? ST_DOLLAR : ST_NL;
        end
        else
        begin
            tail_state = esc_reg ? ST_CARET : ST_CHAR;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        byte_next  = byte_reg;
        esc_next   = esc_reg;
        pad_next   = pad_reg;
        blank_next = blank_reg;
        emit_en    = 1'b0;
        emit_byte  = byte_reg;
        emit_last  = 1'b0;
        dig_ctrl   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    byte_next = in_byte;
                    esc_next  = in_esc;
                    pad_next  = CW'(MIN_WIDTH);
                    if (in_is_nl)
                    begin
                        blank_next = mid_line ? 3'd0 : ((blank_reg != 3'd0) ? 3'd2 : 3'd1);
                    end
                    else
                    begin
                        blank_next = MID_LINE;
                    end
                    if (squeezed)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (do_number)
                    begin
                        dig_ctrl.bump_start = 1'b1;
                        state_next          = ST_BUMP;
                    end
                    else if (in_is_nl)
                    begin
                        emit_en = 1'b1;
                        if (show_ends_reg)
                        begin
                            emit_byte  = CH_DOLLAR;
                            state_next = ST_NL;
                        end
                        else
                        begin
                            emit_byte = CH_NL;
                            emit_last = 1'b1;
                        end
                    end
                    else if (in_esc)
                    begin
                        emit_en    = 1'b1;
                        emit_byte  = CH_CARET;
                        state_next = ST_CHAR;
                    end
                    else
                    begin
                        emit_en   = 1'b1;
                        emit_byte = in_byte;
                        emit_last = 1'b1;
                    end
                end
            end
            ST_BUMP:
            begin
                dig_ctrl.bump_step = 1'b1;
                if (dig_stat.bump_done)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // leading spaces while the column count exceeds the digits in use
                if (pad_reg > CW'(digits_used))
                begin
                    emit_en   = 1'b1;
                    emit_byte = CH_SPACE;
                    if (out_free)
                    begin
                        pad_next = pad_reg - CW'(1);
                    end
                end
                else
                begin
                    dig_ctrl.emit_start = 1'b1;
                    state_next          = ST_DIG;
                end
            end
            ST_DIG:
            begin
                emit_en   = 1'b1;
                emit_byte = dig_stat.digit_char;
                if (out_free)
                begin
                    dig_ctrl.emit_step = 1'b1;
                    if (dig_stat.emit_last)
                    begin
                        state_next = ST_TAB;
                    end
                end
            end
            ST_TAB:
            begin
                emit_en   = 1'b1;
                emit_byte = CH_TAB;
                if (out_free)
                begin
                    state_next = tail_state;
                end
            end
            ST_DOLLAR:
            begin
                emit_en   = 1'b1;
                emit_byte = CH_DOLLAR;
                if (out_free)
                begin
                    state_next = ST_NL;
                end
            end
            ST_NL:
            begin
                emit_en   = 1'b1;
                emit_byte = CH_NL;
                emit_last = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CARET:
            begin
                emit_en   = 1'b1;
                emit_byte = CH_CARET;
                if (out_free)
                begin
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                emit_en   = 1'b1;
                emit_byte = esc_reg ? (byte_reg + CTRL_OFS) : byte_reg;
                emit_last = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            esc_reg   <= 1'b0;
            pad_reg   <= '0;
            blank_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            esc_reg   <= esc_next;
            pad_reg   <= pad_next;
            blank_reg <= blank_next;
        end
    end

    // held byte of the current transaction
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // configuration writes, values masked to register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_mode_reg <= NUM_OFF;
            show_ends_reg   <= 1'b0;
            show_tabs_reg   <= 1'b0;
            squeeze_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NUMBER_MODE:   number_mode_reg <= cfg_data;
                REG_SHOW_ENDS:     show_ends_reg   <= cfg_data[0];
                REG_SHOW_TABS:     show_tabs_reg   <= cfg_data[0];
                REG_SQUEEZE_BLANK: squeeze_reg     <= cfg_data[0];
                default:           number_mode_reg <= number_mode_reg;
            endcase
        end
    end

    // output register parts the sequencer from the downstream stall
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

`ifndef SYNTHESIS
    // a byte that is not the last of its run leaves while the rest is still pending
    a_run_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) |-> (state_reg != ST_IDLE))
        else $error("non-final byte left with the sequencer idle");

    // the counter increment only ends in the padding phase
    a_bump_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUMP) |=> (state_reg == ST_BUMP || state_reg == ST_PAD))
        else $error("counter increment left to an unexpected state");

    // digits in use stay within the counter
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        (digits_used != '0) && (digits_used <= UW'(DIGITS)))
        else $error("digits in use out of range");

    // digits in use only grow, and only during an increment
    a_used_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (digits_used != $past(digits_used)) |->
            ($past(state_reg) == ST_BUMP && digits_used == $past(digits_used) + UW'(1)))
        else $error("digits in use changed outside an increment");
`endif

endmodule

`default_nettype wire

[hw/rtl/tlnf_digits.sv]
// decimal line counter with a shared one-digit increment unit and digit read-out
`default_nettype none

module tlnf_digits
    import tlnf_pkg::*;
#(
    parameter int DIGITS = 18
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dig_ctrl_t                    ctrl,
    output dig_stat_t                         stat,
    output logic [$clog2(DIGITS + 1) - 1:0]   digits_used
);

    localparam int IW = $clog2(DIGITS);
    localparam int UW = $clog2(DIGITS + 1);

    logic [3:0]    digit_reg [DIGITS];
    logic [IW-1:0] ptr_reg, ptr_next;
    logic [UW-1:0] used_reg, used_next;
    logic          ovf_reg, ovf_next;
    logic [3:0]    cur;
    logic          top_pos;
    logic          dig_we;
    logic [3:0]    dig_wdata;

    assign cur         = digit_reg[ptr_reg];
    assign top_pos     = (UW'(ptr_reg) == (used_reg - UW'(1)));
    assign digits_used = used_reg;

    always_comb
    begin
        ptr_next        = ptr_reg;
        used_next       = used_reg;
        ovf_next        = ovf_reg;
        dig_we          = 1'b0;
        dig_wdata       = cur + 4'd1;
        stat.bump_done  = 1'b0;
        stat.emit_last  = (ptr_reg == '0);
        stat.digit_char = (top_pos && ovf_reg) ? CH_GT : (CH_ZERO + {4'd0, cur});
        if (ctrl.bump_start)
        begin
            ptr_next = '0;
        end
        else if (ctrl.bump_step)
        begin
            dig_we = 1'b1;
            if (cur < 4'd9)
            begin
                dig_wdata      = cur + 4'd1;
                stat.bump_done = 1'b1;
            end
            else
            begin
                dig_wdata = 4'd0;
                if (top_pos)
                begin
                    // carry out of the top digit: widen, or mark overflow
                    if (used_reg < UW'(DIGITS))
                    begin
                        used_next = used_reg + UW'(1);
                        ptr_next  = ptr_reg + IW'(1);
                    end
                    else
                    begin
                        ovf_next       = 1'b1;
                        stat.bump_done = 1'b1;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + IW'(1);
                end
            end
        end
        else if (ctrl.emit_start)
        begin
            ptr_next = IW'(used_reg - UW'(1));
        end
        else if (ctrl.emit_step)
        begin
            ptr_next = ptr_reg - IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            used_reg <= UW'(1);
            ovf_reg  <= 1'b0;
            for (int i = 0; i < DIGITS; i++)
            begin
                digit_reg[i] <= 4'd0;
            end
        end
        else
        begin
            ptr_reg  <= ptr_next;
            used_reg <= used_next;
            ovf_reg  <= ovf_next;
            if (dig_we)
            begin
                digit_reg[ptr_reg] <= dig_wdata;
            end
        end
    end

endmodule

`default_nettype wire
